// File: rtl/sti_pkg.sv
// Package for the segment trace intercept unit: widths, defaults and the shared result type.
// No dependencies.
`timescale 1ns / 1ps
package sti_pkg;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned PRESHIFT_DEF   = 8;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Result fields carried down the pipeline.
	typedef struct packed {
		logic               crossed;
		logic               fault;
		logic               bypass;
		logic signed [31:0] frac;
	} res_t;
endpackage

// File: rtl/sti_fmul.sv
// Registered fixed-point multiply: (a*b) >>> FRAC_BITS kept to 32 bits.
// Depends on sti_pkg.
`timescale 1ns / 1ps
module sti_fmul #(
	parameter int unsigned FRAC_BITS = sti_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] p
);
	logic signed [63:0] prod;
	assign prod = a * b;
	always_ff @(posedge clk) begin
		if (en) begin
			p <= 32'(prod >>> FRAC_BITS);
		end
	end
endmodule

// File: rtl/sti_div.sv
// Pipelined signed divider, one quotient bit per stage, saturating to 32 bits.
// Computes (num << FRAC_BITS) / div, truncated toward zero. Depends on sti_pkg.
`timescale 1ns / 1ps
module sti_div #(
	parameter int unsigned FRAC_BITS = sti_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  sti_pkg::res_t      info_in,
	input  logic signed [31:0] num,
	input  logic signed [31:0] div,
	output logic               vld_out,
	output sti_pkg::res_t      res_out
);
	localparam int unsigned NW = 32 + FRAC_BITS;
	localparam int unsigned ST = NW + 1;

	logic [NW-1:0]     quo_s [ST];
	logic [32:0]       rem_s [ST];
	logic [31:0]       dv_s  [ST];
	logic              neg_s [ST];
	logic              vld_s [ST];
	sti_pkg::res_t     inf_s [ST];

	logic [NW-1:0] nabs;
	logic [31:0]   dabs;
	logic [NW-1:0] nfull;
	assign nfull = NW'(num) << FRAC_BITS;
	assign nabs = num[31] ? (~{{FRAC_BITS{num[31]}}, num} + 1'b1) << FRAC_BITS
		: nfull;
	assign dabs = div[31] ? 32'(-div) : div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < ST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s[0] <= nabs;
			rem_s[0] <= '0;
			dv_s[0]  <= dabs;
			neg_s[0] <= num[31] ^ div[31];
			inf_s[0] <= info_in;
			for (int i = 1; i < ST; i++) begin
				logic [32:0] r;
				r = {rem_s[i-1][31:0], quo_s[i-1][NW-1]};
				if (r >= {1'b0, dv_s[i-1]}) begin
					rem_s[i] <= r - {1'b0, dv_s[i-1]};
					quo_s[i] <= {quo_s[i-1][NW-2:0], 1'b1};
				end else begin
					rem_s[i] <= r;
					quo_s[i] <= {quo_s[i-1][NW-2:0], 1'b0};
				end
				dv_s[i]  <= dv_s[i-1];
				neg_s[i] <= neg_s[i-1];
				inf_s[i] <= inf_s[i-1];
			end
		end
	end

	logic [NW-1:0] q;
	logic          ovp, ovn;
	assign q   = quo_s[ST-1];
	assign ovp = q > NW'(32'h7FFF_FFFF);
	assign ovn = q > NW'(33'h0_8000_0000);

	assign vld_out = vld_s[ST-1];
	always_comb begin
		res_out = inf_s[ST-1];
		if (!res_out.bypass) begin
			if (neg_s[ST-1])
				res_out.frac = ovn ? 32'sh8000_0000 : 32'(-q);
			else
				res_out.frac = ovp ? 32'sh7FFF_FFFF : 32'(q);
		end
	end
endmodule

// File: rtl/segment_trace_intercept_unit.sv
// Segment versus trace crossing test, fully pipelined.
// Stages s1 to s4, the divider stages and the output register; throughput one
// item per cycle unless an output stall holds it. A stall freezes the whole pipeline.
// Reset clears valid bits only. Depends on sti_pkg, sti_fmul, sti_div.
`timescale 1ns / 1ps
module segment_trace_intercept_unit #(
	parameter int unsigned PRESHIFT  = sti_pkg::PRESHIFT_DEF,
	parameter int unsigned FRAC_BITS = sti_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] seg_start_x,
	input  logic signed [31:0] seg_start_y,
	input  logic signed [31:0] seg_end_x,
	input  logic signed [31:0] seg_end_y,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_delta_x,
	input  logic signed [31:0] ray_delta_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               crossed,
	output logic signed [31:0] hit_fraction,
	output logic               divide_fault
);
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// s1: differences and pre-shift
	logic signed [31:0] nx_s1, ny_s1, dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [31:0] ldx_s1, ldy_s1, ex_s1, ey_s1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			ny_s1  <= (-ray_delta_x) >>> PRESHIFT;
			nx_s1  <= ray_delta_y >>> PRESHIFT;
			dx1_s1 <= (seg_start_x - ray_origin_x) >>> PRESHIFT;
			dy1_s1 <= (seg_start_y - ray_origin_y) >>> PRESHIFT;
			dx2_s1 <= (seg_end_x - ray_origin_x) >>> PRESHIFT;
			dy2_s1 <= (seg_end_y - ray_origin_y) >>> PRESHIFT;
			ldy_s1 <= (seg_start_y - seg_end_y) >>> PRESHIFT;
			ldx_s1 <= (seg_end_x - seg_start_x) >>> PRESHIFT;
			ex_s1  <= ((ray_origin_x + ray_delta_x) - seg_start_x) >>> PRESHIFT;
			ey_s1  <= ((ray_origin_y + ray_delta_y) - seg_start_y) >>> PRESHIFT;
		end
	end

	// s2: eight products
	logic signed [31:0] pl0, pl1, pr0, pr1, pn0, pn1, pd0, pd1;
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clk, .en, .a(dx1_s1), .b(nx_s1), .p(pl0));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk, .en, .a(dy1_s1), .b(ny_s1), .p(pl1));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clk, .en, .a(dx2_s1), .b(nx_s1), .p(pr0));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clk, .en, .a(dy2_s1), .b(ny_s1), .p(pr1));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clk, .en, .a(dx1_s1), .b(ldy_s1), .p(pn0));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.clk, .en, .a(dy1_s1), .b(ldx_s1), .p(pn1));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m6 (.clk, .en, .a(ex_s1), .b(ldy_s1), .p(pd0));
	sti_fmul #(.FRAC_BITS(FRAC_BITS)) u_m7 (.clk, .en, .a(ey_s1), .b(ldx_s1), .p(pd1));

	// s3: sums
	logic signed [31:0] left_s3, right_s3, num_s3, den_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			left_s3  <= pl0 + pl1;
			right_s3 <= pr0 + pr1;
			num_s3   <= pn0 + pn1;
			den_s3   <= pd0 + pd1;
		end
	end

	// s4: side test and divisor
	logic signed [31:0] num_s4, dvs_s4;
	sti_pkg::res_t      inf_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_s3;
			dvs_s4 <= num_s3 + den_s3;
			inf_s4.crossed <= left_s3[31] != right_s3[31];
			inf_s4.fault   <= (left_s3[31] != right_s3[31]) && (num_s3 + den_s3 == 32'sd0);
			inf_s4.bypass  <= (left_s3[31] == right_s3[31]) || (num_s3 + den_s3 == 32'sd0);
			inf_s4.frac    <= (left_s3[31] == right_s3[31]) ? -32'sd1 : 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	sti_pkg::res_t res;
	sti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n, .en, .vld_in(v_s4), .info_in(inf_s4),
		.num(num_s4), .div(dvs_s4), .vld_out(v_s5), .res_out(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			crossed      <= res.crossed;
			hit_fraction <= res.frac;
			divide_fault <= res.fault;
		end
	end

	a_fault_crossed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> crossed)
		else $error("fault without crossing");
	a_not_crossed_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crossed |-> hit_fraction == -32'sd1 && !divide_fault)
		else $error("bad not-crossed result");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_fraction))
		else $error("output changed under stall");
endmodule
